### hw/rtl/etdb_pkg.sv
`default_nettype none

package etdb_pkg;

  localparam int unsigned CH_NUM  = 8;
  localparam int unsigned IDX_W   = $clog2(CH_NUM);
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DB_W    = 16;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic                ACTIVE_LOW_RST = 1'b1;
  localparam logic [DB_W-1:0]     DEBOUNCE_RST   = DB_W'(50);
  localparam logic [CNT_W-1:0]    CH_COUNT_RST   = CNT_W'(8);

  typedef enum logic [1:0] {
    REG_ACTIVE_LOW = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_CH_COUNT   = 2'd2
  } reg_idx_e;

  // One memory word per channel.
  typedef struct packed {
    logic              stable;
    logic              deb;
    logic [TIME_W-1:0] start;
    logic              base;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              is_begin;
    logic              used;
    logic              level;
    logic              edge_hit;
    logic [TIME_W-1:0] now;
    logic [DB_W-1:0]   window;
  } upd_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/etdb_ram.sv
`default_nettype none

module etdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/etdb_update.sv
`default_nettype none

module etdb_update (
  input  wire etdb_pkg::entry_t    entry_i,
  input  wire etdb_pkg::upd_ctrl_t ctrl_i,
  output etdb_pkg::entry_t         entry_o,
  output logic                     event_o
);
  import etdb_pkg::*;

  always_comb begin
    logic [TIME_W-1:0] elapsed;
    entry_o = entry_i;
    event_o = 1'b0;
    elapsed = '0;
    if (ctrl_i.is_begin) begin
      entry_o        = '0;
      entry_o.stable = ctrl_i.used & ctrl_i.level;
    end else begin
      // open a window only on an idle channel
      if (ctrl_i.edge_hit && !entry_i.deb) begin
        entry_o.deb   = 1'b1;
        entry_o.start = ctrl_i.now;
      end
      elapsed = ctrl_i.now - entry_o.start;
      if (entry_o.deb && (elapsed >= TIME_W'(ctrl_i.window))) begin
        if (ctrl_i.level != entry_o.stable) begin
          entry_o.stable = ctrl_i.level;
          if (entry_o.base) begin
            event_o = 1'b1;
          end else begin
            entry_o.base = 1'b1;
          end
        end
        entry_o.deb = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/edge_triggered_multi_input_debounce_top.sv
`default_nettype none

// Channel | Dir | Handshake                  | Payload
// in      | in  | in_valid_i / in_stall_o    | command_i, now_ms_i, pin_levels_i, edge_flags_i
// out     | out | out_valid_o / out_stall_i  | channel_index_o, new_state_o, event_time_o, last_o
// cfg     | in  | APB psel/penable/pready    | pwdata / prdata at paddr
//
// A poll does one read-modify-write of the channel memory per channel in use
// (channel_count, saturated at 8); a poll with no channels in use reads and writes no
// memory. A begin does one memory write per channel, for all 8 channels. Items follow
// each other without gaps unless out_stall_i holds the pipeline.
// Unstalled, events leave one per cycle; the final event of a poll is held until the poll ends.
// Reset: per-entry valid flags make the channel memory read as zero; no clearing pass.
// out_stall_i holds the write-back stage, which holds the read stage and the input.

module edge_triggered_multi_input_debounce_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [etdb_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic [etdb_pkg::CH_NUM-1:0]   pin_levels_i,
  input  wire logic [etdb_pkg::CH_NUM-1:0]   edge_flags_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [etdb_pkg::IDX_W-1:0]    channel_index_o,
  output logic                               new_state_o,
  output logic      [etdb_pkg::TIME_W-1:0]   event_time_o,
  output logic                               last_o,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [etdb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [etdb_pkg::DATA_W-1:0]   pwdata,
  output logic      [etdb_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import etdb_pkg::*;

  // configuration
  logic              active_low_q;
  logic [DB_W-1:0]   debounce_ms_q;
  logic [CNT_W-1:0]  ch_count_q;
  logic [CNT_W-1:0]  n_eff;
  reg_idx_e          reg_idx;
  logic              cfg_we;

  // read stage
  logic              busy_q, busy_d;
  logic              cmd_q;
  logic [TIME_W-1:0] now_q;
  logic [CH_NUM-1:0] levels_q;
  logic [CH_NUM-1:0] edges_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_idx_q;
  logic              rd_go, rd_last, in_accept;

  // write-back stage
  logic              wb_valid_q, wb_valid_d;
  logic              wb_cmd_q;
  logic [IDX_W-1:0]  wb_idx_q;
  logic              wb_final_q;
  logic [TIME_W-1:0] wb_now_q;
  logic              wb_level_q;
  logic              wb_edge_q;
  logic              wb_used_q;
  logic              wb_go, wb_event, wb_block;

  // memory and forwarding
  logic [CH_NUM-1:0] vld_q;
  logic              rd_vld_q;
  logic              rd_fwd_q;
  entry_t            fwd_data_q;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            entry_rd, entry_wr;
  upd_ctrl_t         upd_ctrl;
  logic              upd_event;

  // pending event and output
  logic              pend_valid_q, pend_valid_d;
  logic              pend_end_q, pend_end_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  logic              pend_state_q, pend_state_d;
  logic [TIME_W-1:0] pend_time_q, pend_time_d;
  logic              out_free, push;
  logic              out_valid_q;

  // ---------------------------------------------------------------- config
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q  <= ACTIVE_LOW_RST;
      debounce_ms_q <= DEBOUNCE_RST;
      ch_count_q    <= CH_COUNT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ACTIVE_LOW: active_low_q  <= pwdata[0];
        REG_DEBOUNCE:   debounce_ms_q <= pwdata[DB_W-1:0];
        REG_CH_COUNT:   ch_count_q    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_LOW: prdata = DATA_W'(active_low_q);
      REG_DEBOUNCE:   prdata = DATA_W'(debounce_ms_q);
      REG_CH_COUNT:   prdata = DATA_W'(ch_count_q);
      default:        prdata = '0;
    endcase
  end

  assign n_eff = (ch_count_q > CNT_W'(CH_NUM)) ? CNT_W'(CH_NUM) : ch_count_q;

  // ---------------------------------------------------------------- read stage
  assign rd_last    = (idx_q == last_idx_q);
  assign rd_go      = busy_q && (!wb_valid_q || wb_go);
  assign in_stall_o = busy_q && !(rd_go && rd_last);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (rd_go) begin
      if (rd_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (in_accept) begin
      busy_d = command_i || (n_eff != '0);
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= command_i;
      now_q      <= now_ms_i;
      levels_q   <= pin_levels_i;
      edges_q    <= edge_flags_i;
      last_idx_q <= command_i ? IDX_W'(CH_NUM - 1) : IDX_W'(n_eff - 1'b1);
    end
  end

  // ---------------------------------------------------------------- memory
  etdb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CH_NUM)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wb_go),
    .waddr_i (wb_idx_q),
    .wdata_i (entry_wr),
    .re_i    (rd_go),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // forward a write that lands on the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_fwd_q <= 1'b0;
    end else begin
      if (wb_go) begin
        vld_q[wb_idx_q] <= 1'b1;
      end
      if (rd_go) begin
        rd_vld_q <= vld_q[idx_q];
        rd_fwd_q <= wb_go && (wb_idx_q == idx_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      fwd_data_q <= entry_wr;
    end
  end

  assign entry_rd = rd_fwd_q ? fwd_data_q : (rd_vld_q ? entry_t'(ram_rdata) : '0);

  // ---------------------------------------------------------------- write-back
  always_comb begin
    wb_valid_d = wb_valid_q;
    if (rd_go) begin
      wb_valid_d = 1'b1;
    end else if (wb_go) begin
      wb_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= wb_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      wb_cmd_q   <= cmd_q;
      wb_idx_q   <= idx_q;
      wb_final_q <= rd_last;
      wb_now_q   <= now_q;
      wb_level_q <= levels_q[idx_q] ^ active_low_q;
      wb_edge_q  <= edges_q[idx_q];
      wb_used_q  <= CNT_W'(idx_q) < n_eff;
    end
  end

  assign upd_ctrl = '{
    is_begin: wb_cmd_q,
    used:     wb_used_q,
    level:    wb_level_q,
    edge_hit: wb_edge_q,
    now:      wb_now_q,
    window:   debounce_ms_q
  };

  etdb_update u_update (
    .entry_i (entry_rd),
    .ctrl_i  (upd_ctrl),
    .entry_o (entry_wr),
    .event_o (upd_event)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign wb_event = wb_valid_q && !wb_cmd_q && upd_event;
  assign wb_block = wb_event && pend_valid_q && !out_free;
  assign wb_go    = wb_valid_q && !wb_block;
  // a newer event proves the pending one is not the last of its poll
  assign push     = pend_valid_q && out_free && (pend_end_q || wb_event);

  // ---------------------------------------------------------------- pending event
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_end_d   = pend_end_q;
    pend_idx_d   = pend_idx_q;
    pend_state_d = pend_state_q;
    pend_time_d  = pend_time_q;
    if (push) begin
      pend_valid_d = 1'b0;
    end
    if (wb_go && wb_event) begin
      pend_valid_d = 1'b1;
      pend_end_d   = wb_final_q;
      pend_idx_d   = wb_idx_q;
      pend_state_d = wb_level_q;
      pend_time_d  = wb_now_q;
    end else if (wb_go && wb_final_q && !wb_cmd_q && pend_valid_q && !push) begin
      pend_end_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_end_q   <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_end_q   <= pend_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    pend_state_q <= pend_state_d;
    pend_time_q  <= pend_time_d;
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      channel_index_o <= pend_idx_q;
      new_state_o     <= pend_state_q;
      event_time_o    <= pend_time_q;
      last_o          <= pend_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------- assertions
  a_wb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q && !wb_go |=> wb_valid_q && $stable(wb_idx_q))
    else $error("write-back stage dropped a stalled channel");

  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !push |=> pend_valid_q)
    else $error("pending event lost without being sent");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && rd_go && !rd_last |=> busy_q && (idx_q == $past(idx_q) + 1'b1))
    else $error("channel sweep skipped or ended early");

endmodule

`default_nettype wire
